@@ rtl/art_pkg.sv @@
// ----------------------------------------------------------------------------
// art_pkg
// Shared types, codes and sizes of the address region table.
// ----------------------------------------------------------------------------
package art_pkg;

  localparam int unsigned CAPACITY  = 32;
  localparam int unsigned IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W     = $clog2(CAPACITY + 1);
  localparam int unsigned SLOT_W    = 5;
  localparam int unsigned PAGE_BITS = 12;

  localparam logic [1:0] KIND_DIRECT = 2'd0;

  typedef enum logic {
    CMD_INSTALL  = 1'b0,
    CMD_CLASSIFY = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_PAGE    = 2'd1,
    ST_OVERLAP = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FIT_NONE     = 2'd0,
    FIT_STRADDLE = 2'd1,
    FIT_INSIDE   = 2'd2
  } fit_e;

  typedef struct packed {
    logic [31:0] base;
    logic [31:0] size;
    logic [1:0]  kind;
    logic [31:0] attr;
    logic [63:0] host;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // Controller to datapath
  typedef struct packed {
    logic idle;
    logic take;
    logic scan_clear;
    logic scan_step;
    logic finish;
  } art_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic req_valid;
    logic is_install;
    logic page_bad;
    logic empty;
    logic hit;
    logic scan_last;
    logic out_free;
  } art_stat_t;

  function automatic logic [SLOT_W-1:0] slot_index(input logic [IDX_W-1:0] slot);
    logic [IDX_W+SLOT_W-1:0] wide;
    wide = {{SLOT_W{1'b0}}, slot};
    return wide[SLOT_W-1:0];
  endfunction

endpackage

@@ rtl/art_if.sv @@
// ----------------------------------------------------------------------------
// art_req_if / art_rsp_if
// Request and response channels of the address region table.
// ----------------------------------------------------------------------------
interface art_req_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] region_base;
  logic [31:0] region_size;
  logic [1:0]  region_kind;
  logic [31:0] region_attr;
  logic [63:0] host_address;
  logic [31:0] access_address;
  logic [31:0] access_size;

  modport source (
    output valid, command, region_base, region_size, region_kind, region_attr,
           host_address, access_address, access_size,
    input  ready
  );
  modport sink (
    input  valid, command, region_base, region_size, region_kind, region_attr,
           host_address, access_address, access_size,
    output ready
  );
endinterface

interface art_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  install_status;
  logic [1:0]  fit;
  logic [4:0]  region_index;
  logic [31:0] found_base;
  logic [31:0] found_size;
  logic [1:0]  found_kind;
  logic [31:0] found_attr;
  logic [63:0] found_host;
  logic [63:0] map_address;
  logic        map_access_flag;

  modport source (
    output valid, install_status, fit, region_index, found_base, found_size,
           found_kind, found_attr, found_host, map_address, map_access_flag,
    input  ready
  );
  modport sink (
    input  valid, install_status, fit, region_index, found_base, found_size,
           found_kind, found_attr, found_host, map_address, map_access_flag,
    output ready
  );
endinterface

@@ rtl/art_ram.sv @@
// ----------------------------------------------------------------------------
// art_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module art_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/art_datapath.sv @@
// ----------------------------------------------------------------------------
// art_datapath
// Request register, entry RAM, scan compare pipeline and result register.
// ----------------------------------------------------------------------------
module art_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  art_req_if.sink           req_i,
  art_rsp_if.source         rsp_o,
  input  art_pkg::art_cmd_t cmd_i,
  output art_pkg::art_stat_t stat_o
);
  import art_pkg::*;

  // Request fields
  logic        cmd_q;
  logic [31:0] base_q;
  logic [31:0] size_q;
  logic [1:0]  kind_q;
  logic [31:0] attr_q;
  logic [63:0] host_q;
  logic [31:0] addr_q;
  logic [31:0] len_q;

  // Scan state
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] rd_idx_q;
  logic             cmp_vld_q;
  logic [IDX_W-1:0] cmp_idx_q;
  logic             hit_q;
  fit_e             fit_q;
  entry_t           found_q;
  logic [IDX_W-1:0] found_idx_q;

  // Result register
  logic        out_vld_q;
  logic [1:0]  o_status_q, o_status_d;
  logic [1:0]  o_fit_q, o_fit_d;
  logic [4:0]  o_idx_q, o_idx_d;
  entry_t      o_ent_q, o_ent_d;
  logic [63:0] o_map_q, o_map_d;
  logic        o_flag_q, o_flag_d;

  entry_t      new_entry;
  entry_t      rd_entry;
  logic        is_install;
  logic        page_bad;
  logic        full;
  logic        rd_issue;
  logic        wr_en;
  logic        out_free;
  logic [31:0] end_new;
  logic [31:0] end_old;
  logic [31:0] offset;
  logic [31:0] room;
  logic        overlap;
  logic        contain;
  logic        match;
  fit_e        fit_c;

  assign is_install = (cmd_e'(cmd_q) == CMD_INSTALL);
  assign page_bad   = (size_q == 32'd0) || (base_q[PAGE_BITS-1:0] != '0)
                      || (size_q[PAGE_BITS-1:0] != '0);
  assign full       = (count_q == CNT_W'(CAPACITY));
  assign out_free   = !out_vld_q || rsp_o.ready;
  assign rd_issue   = cmd_i.scan_step && (rd_idx_q < count_q);

  assign new_entry.base = base_q;
  assign new_entry.size = size_q;
  assign new_entry.kind = kind_q;
  assign new_entry.attr = attr_q;
  assign new_entry.host = host_q;

  assign wr_en = cmd_i.finish && is_install && !page_bad && !hit_q && !full;

  art_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (new_entry),
    .re_i    (rd_issue),
    .raddr_i (rd_idx_q[IDX_W-1:0]),
    .rdata_o (rd_entry)
  );

  // Compare the entry read in the previous cycle; ends wrap modulo 2^32
  always_comb begin
    end_new = base_q + size_q;
    end_old = rd_entry.base + rd_entry.size;
    overlap = (base_q < end_old) && (rd_entry.base < end_new);
    offset  = addr_q - rd_entry.base;
    contain = (addr_q >= rd_entry.base) && (offset < rd_entry.size);
    room    = rd_entry.size - offset;
    fit_c   = ((len_q == 32'd0) || (len_q > room)) ? FIT_STRADDLE : FIT_INSIDE;
    match   = is_install ? overlap : contain;
  end

  assign stat_o.req_valid  = req_i.valid;
  assign stat_o.is_install = is_install;
  assign stat_o.page_bad   = page_bad;
  assign stat_o.empty      = (count_q == '0);
  assign stat_o.hit        = cmp_vld_q && match;
  assign stat_o.scan_last  = cmp_vld_q
                             && ((CNT_W'(cmp_idx_q) + CNT_W'(1)) == count_q);
  assign stat_o.out_free   = out_free;

  // Result fields; anything without meaning stays zero
  always_comb begin
    o_status_d = ST_OK;
    o_fit_d    = FIT_NONE;
    o_idx_d    = '0;
    o_ent_d    = '0;
    o_map_d    = '0;
    o_flag_d   = 1'b0;
    if (is_install) begin
      if (page_bad) begin
        o_status_d = ST_PAGE;
      end else if (hit_q) begin
        o_status_d = ST_OVERLAP;
        o_idx_d    = slot_index(found_idx_q);
        o_ent_d    = found_q;
      end else if (full) begin
        o_status_d = ST_FULL;
      end else begin
        o_idx_d  = slot_index(count_q[IDX_W-1:0]);
        o_ent_d  = new_entry;
        o_flag_d = (kind_q == KIND_DIRECT);
        o_map_d  = (kind_q == KIND_DIRECT) ? host_q : {32'd0, base_q};
      end
    end else if (hit_q) begin
      o_fit_d = fit_q;
      o_idx_d = slot_index(found_idx_q);
      o_ent_d = found_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      rd_idx_q  <= '0;
      cmp_vld_q <= 1'b0;
      hit_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cmd_i.take) begin
        hit_q <= 1'b0;
      end else if (cmd_i.scan_step && cmp_vld_q && match) begin
        hit_q <= 1'b1;
      end
      if (cmd_i.scan_clear) begin
        rd_idx_q  <= '0;
        cmp_vld_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        cmp_vld_q <= rd_issue;
        if (rd_issue) begin
          rd_idx_q <= rd_idx_q + CNT_W'(1);
        end
      end
      if (wr_en) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (cmd_i.finish) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      cmd_q  <= req_i.command;
      base_q <= req_i.region_base;
      size_q <= req_i.region_size;
      kind_q <= req_i.region_kind;
      attr_q <= req_i.region_attr;
      host_q <= req_i.host_address;
      addr_q <= req_i.access_address;
      len_q  <= req_i.access_size;
    end
    if (cmd_i.scan_step) begin
      cmp_idx_q <= rd_idx_q[IDX_W-1:0];
      if (cmp_vld_q && match) begin
        found_q     <= rd_entry;
        found_idx_q <= cmp_idx_q;
        fit_q       <= fit_c;
      end
    end
    if (cmd_i.finish) begin
      o_status_q <= o_status_d;
      o_fit_q    <= o_fit_d;
      o_idx_q    <= o_idx_d;
      o_ent_q    <= o_ent_d;
      o_map_q    <= o_map_d;
      o_flag_q   <= o_flag_d;
    end
  end

  assign req_i.ready           = cmd_i.idle;
  assign rsp_o.valid           = out_vld_q;
  assign rsp_o.install_status  = o_status_q;
  assign rsp_o.fit             = o_fit_q;
  assign rsp_o.region_index    = o_idx_q;
  assign rsp_o.found_base      = o_ent_q.base;
  assign rsp_o.found_size      = o_ent_q.size;
  assign rsp_o.found_kind      = o_ent_q.kind;
  assign rsp_o.found_attr      = o_ent_q.attr;
  assign rsp_o.found_host      = o_ent_q.host;
  assign rsp_o.map_address     = o_map_q;
  assign rsp_o.map_access_flag = o_flag_q;

endmodule

@@ rtl/art_ctrl.sv @@
// ----------------------------------------------------------------------------
// art_ctrl
// Sequencer: take a request, set up, scan the table, hand off the result.
// ----------------------------------------------------------------------------
module art_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  art_pkg::art_stat_t  stat_i,
  output art_pkg::art_cmd_t   cmd_o
);
  import art_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_FINISH
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o            = '0;
    state_d          = state_q;
    cmd_o.idle       = (state_q == S_IDLE);
    cmd_o.take       = (state_q == S_IDLE) && stat_i.req_valid;
    cmd_o.scan_clear = (state_q == S_START);
    cmd_o.scan_step  = (state_q == S_SCAN);
    cmd_o.finish     = (state_q == S_FINISH) && stat_i.out_free;
    case (state_q)
      S_IDLE: begin
        if (stat_i.req_valid) state_d = S_START;
      end
      S_START: begin
        // skip the scan for a malformed install or an empty table
        if ((stat_i.is_install && stat_i.page_bad) || stat_i.empty) begin
          state_d = S_FINISH;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat_i.hit || stat_i.scan_last) state_d = S_FINISH;
      end
      S_FINISH: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/address_region_table.sv @@
// ----------------------------------------------------------------------------
// address_region_table
// Region table with install and classify requests, one response per request.
// ----------------------------------------------------------------------------
// One request is worked at a time. A request passes from acceptance to a
// registered response through accept, setup, a scan through the single read
// port of the entry RAM, and result load, which waits until the response
// register is free; an install refused for page alignment, or any request on
// an empty table, skips the scan. The scan stops at the first hit.
// The response register lets the next request be accepted while the previous
// response waits for ready. No clearing pass is needed after reset.
module address_region_table (
  input  logic      clk_i,
  input  logic      rst_ni,
  art_req_if.sink   req_i,
  art_rsp_if.source rsp_o
);
  import art_pkg::*;

  art_cmd_t  cmd;
  art_stat_t stat;

  art_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  art_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .rsp_o  (rsp_o),
    .cmd_i  (cmd),
    .stat_o (stat)
  );

endmodule

@@ rtl/art_checker.sv @@
// ----------------------------------------------------------------------------
// art_checker
// Port-level checks of the address region table, bound to the top level.
// ----------------------------------------------------------------------------
module art_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [1:0]  install_status,
  input logic [1:0]  fit,
  input logic [4:0]  region_index,
  input logic [31:0] found_base,
  input logic [63:0] map_address,
  input logic        map_access_flag
);
  import art_pkg::*;

  // Hold a stalled response
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(install_status)
      && $stable(fit) && $stable(region_index) && $stable(map_address))
    else $error("response changed while stalled");

  // One request in work at a time
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in work");

  a_classify_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && (fit != FIT_NONE) |-> (install_status == ST_OK)
      && !map_access_flag && (map_address == 64'd0))
    else $error("classify response carries install fields");

  a_refusal_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && ((install_status == ST_PAGE) || (install_status == ST_FULL))
      |-> (region_index == 5'd0) && (found_base == 32'd0) && !map_access_flag)
    else $error("refused install reports a region");

  a_flag_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && map_access_flag |-> (install_status == ST_OK) && (fit == FIT_NONE))
    else $error("access flag set on a refused or classify response");

endmodule

bind address_region_table art_checker u_art_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid       (req_i.valid),
  .req_ready       (req_i.ready),
  .rsp_valid       (rsp_o.valid),
  .rsp_ready       (rsp_o.ready),
  .install_status  (rsp_o.install_status),
  .fit             (rsp_o.fit),
  .region_index    (rsp_o.region_index),
  .found_base      (rsp_o.found_base),
  .map_address     (rsp_o.map_address),
  .map_access_flag (rsp_o.map_access_flag)
);
